/* rtl/core/color_dominance_mask_centroid_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the blue-dominance centroid block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef COLOR_DOMINANCE_MASK_CENTROID_DEFINES_SVH
`define COLOR_DOMINANCE_MASK_CENTROID_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDMC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cdmc_pkg.sv */
// ---------------------------------------------------------------------------
// cdmc_pkg
// Types and constants shared by the blue-dominance centroid block.
// ---------------------------------------------------------------------------
package cdmc_pkg;

  localparam int COLOR_W = 8;
  localparam int THR_W   = 8;
  localparam int SIZE_W  = 11;
  localparam int CENT_W  = 10;
  localparam int COUNT_W = 21;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_MARGIN = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [THR_W-1:0]  RST_MARGIN = 8'd0;
  localparam logic [SIZE_W-1:0] RST_WIDTH  = 11'd320;
  localparam logic [SIZE_W-1:0] RST_HEIGHT = 11'd240;

  typedef struct packed {
    logic [THR_W-1:0]  margin;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
  } ctrl_sts_t;

  typedef struct packed {
    logic               mask;
    logic               frame_done;
    logic               found;
    logic [CENT_W-1:0]  centroid_x;
    logic [CENT_W-1:0]  centroid_y;
    logic [COUNT_W-1:0] hit_count;
  } res_t;

endpackage

/* rtl/core/cdmc_ifs.sv */
// ---------------------------------------------------------------------------
// cdmc channel interfaces
// Valid/ready channels for pixel items and result items.
// ---------------------------------------------------------------------------
interface cdmc_pix_if;
  logic                          valid;
  logic                          ready;
  logic [cdmc_pkg::COLOR_W-1:0]  red;
  logic [cdmc_pkg::COLOR_W-1:0]  green;
  logic [cdmc_pkg::COLOR_W-1:0]  blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface cdmc_res_if;
  logic                          valid;
  logic                          ready;
  logic                          mask;
  logic                          frame_done;
  logic                          found;
  logic [cdmc_pkg::CENT_W-1:0]   centroid_x;
  logic [cdmc_pkg::CENT_W-1:0]   centroid_y;
  logic [cdmc_pkg::COUNT_W-1:0]  hit_count;

  modport source (output valid, mask, frame_done, found, centroid_x, centroid_y,
                  hit_count, input ready);
  modport sink (input valid, mask, frame_done, found, centroid_x, centroid_y,
                hit_count, output ready);
endinterface

/* rtl/core/cdmc_regs.sv */
// ---------------------------------------------------------------------------
// cdmc_regs
// APB-style configuration registers: margin, frame width and frame height.
// ---------------------------------------------------------------------------
module cdmc_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cdmc_pkg::ADDR_W-1:0]   paddr,
  input  logic [cdmc_pkg::DATA_W-1:0]   pwdata,
  output logic [cdmc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output cdmc_pkg::cfg_t                cfg
);

  cdmc_pkg::cfg_t                cfg_r;
  cdmc_pkg::cfg_t                cfg_nxt;
  logic [cdmc_pkg::IDX_W-1:0]    idx;
  logic                          wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[cdmc_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        cdmc_pkg::REG_MARGIN: cfg_nxt.margin = pwdata[cdmc_pkg::THR_W-1:0];
        cdmc_pkg::REG_WIDTH:  cfg_nxt.width  = pwdata[cdmc_pkg::SIZE_W-1:0];
        cdmc_pkg::REG_HEIGHT: cfg_nxt.height = pwdata[cdmc_pkg::SIZE_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      cdmc_pkg::REG_MARGIN: prdata = cdmc_pkg::DATA_W'(cfg_r.margin);
      cdmc_pkg::REG_WIDTH:  prdata = cdmc_pkg::DATA_W'(cfg_r.width);
      cdmc_pkg::REG_HEIGHT: prdata = cdmc_pkg::DATA_W'(cfg_r.height);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.margin <= cdmc_pkg::RST_MARGIN;
      cfg_r.width  <= cdmc_pkg::RST_WIDTH;
      cfg_r.height <= cdmc_pkg::RST_HEIGHT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/core/cdmc_dp.sv */
// ---------------------------------------------------------------------------
// cdmc_dp
// Datapath: mask test, raster counters, coordinate sums and a pair of
// restoring dividers that produce the centroid one bit per cycle.
// ---------------------------------------------------------------------------
module cdmc_dp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int QW         = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cdmc_pkg::cfg_t                cfg,
  input  logic [cdmc_pkg::COLOR_W-1:0]  red,
  input  logic [cdmc_pkg::COLOR_W-1:0]  green,
  input  logic [cdmc_pkg::COLOR_W-1:0]  blue,
  input  cdmc_pkg::ctrl_cmd_t           cmd,
  output cdmc_pkg::ctrl_sts_t           sts,
  output cdmc_pkg::res_t                res
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int NW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int DW   = QW + NW;
  localparam int SZA  = (CW > RW) ? CW + 1 : RW + 1;
  localparam int SZW  = (SZA > cdmc_pkg::SIZE_W) ? SZA : cdmc_pkg::SIZE_W;
  localparam int CMPW = cdmc_pkg::COLOR_W + 1;

  logic [CW-1:0]   col_r;
  logic [RW-1:0]   row_r;
  logic [DW-1:0]   sum_x_r;
  logic [DW-1:0]   sum_y_r;
  logic [NW-1:0]   cnt_r;
  logic [QW-1:0]   cx_r;
  logic [QW-1:0]   cy_r;
  logic [NW-1:0]   rem_x_r;
  logic [NW-1:0]   rem_y_r;
  logic [QW-1:0]   dq_x_r;
  logic [QW-1:0]   dq_y_r;
  logic [NW-1:0]   div_r;
  logic            pend_mask_r;
  logic [NW-1:0]   pend_cnt_r;
  cdmc_pkg::res_t  res_r;

  logic [SZW-1:0]  w_ext;
  logic [SZW-1:0]  h_ext;
  logic [SZW-1:0]  w_eff;
  logic [SZW-1:0]  h_eff;
  logic            line_end;
  logic            frame_end;
  logic            marked;
  logic [DW-1:0]   sum_x_new;
  logic [DW-1:0]   sum_y_new;
  logic [NW-1:0]   cnt_new;
  logic [NW:0]     trial_x;
  logic [NW:0]     trial_y;
  logic            ge_x;
  logic            ge_y;
  logic [NW-1:0]   rem_x_nxt;
  logic [NW-1:0]   rem_y_nxt;
  logic [QW-1:0]   dq_x_nxt;
  logic [QW-1:0]   dq_y_nxt;

  assign w_ext = SZW'(cfg.width);
  assign h_ext = SZW'(cfg.height);
  assign w_eff = (w_ext == '0) ? SZW'(1) :
                 (w_ext > SZW'(MAX_WIDTH)) ? SZW'(MAX_WIDTH) : w_ext;
  assign h_eff = (h_ext == '0) ? SZW'(1) :
                 (h_ext > SZW'(MAX_HEIGHT)) ? SZW'(MAX_HEIGHT) : h_ext;

  assign line_end  = (SZW'(col_r) + SZW'(1)) >= w_eff;
  assign frame_end = line_end && ((SZW'(row_r) + SZW'(1)) >= h_eff);

  assign marked = (CMPW'(blue) > (CMPW'(red) + CMPW'(cfg.margin))) &&
                  (CMPW'(blue) > (CMPW'(green) + CMPW'(cfg.margin)));

  assign sum_x_new = marked ? (sum_x_r + DW'(col_r)) : sum_x_r;
  assign sum_y_new = marked ? (sum_y_r + DW'(row_r)) : sum_y_r;
  assign cnt_new   = marked ? (cnt_r + NW'(1)) : cnt_r;

  assign sts.need_div = frame_end && (cnt_new != '0);

  assign trial_x   = {rem_x_r, dq_x_r[QW-1]};
  assign trial_y   = {rem_y_r, dq_y_r[QW-1]};
  assign ge_x      = trial_x >= {1'b0, div_r};
  assign ge_y      = trial_y >= {1'b0, div_r};
  assign rem_x_nxt = ge_x ? NW'(trial_x - {1'b0, div_r}) : trial_x[NW-1:0];
  assign rem_y_nxt = ge_y ? NW'(trial_y - {1'b0, div_r}) : trial_y[NW-1:0];
  assign dq_x_nxt  = (dq_x_r << 1) | QW'(ge_x);
  assign dq_y_nxt  = (dq_y_r << 1) | QW'(ge_y);

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      cnt_r   <= '0;
      cx_r    <= '0;
      cy_r    <= '0;
    end else if (cmd.load) begin
      if (line_end) begin
        col_r <= '0;
        row_r <= frame_end ? '0 : row_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
      if (frame_end) begin
        sum_x_r <= '0;
        sum_y_r <= '0;
        cnt_r   <= '0;
      end else begin
        sum_x_r <= sum_x_new;
        sum_y_r <= sum_y_new;
        cnt_r   <= cnt_new;
      end
    end else if (cmd.finish) begin
      cx_r <= dq_x_nxt;
      cy_r <= dq_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_x_r     <= sum_x_new[DW-1:QW];
      rem_y_r     <= sum_y_new[DW-1:QW];
      dq_x_r      <= sum_x_new[QW-1:0];
      dq_y_r      <= sum_y_new[QW-1:0];
      div_r       <= cnt_new;
      pend_mask_r <= marked;
      pend_cnt_r  <= cnt_new;
      if (!sts.need_div) begin
        res_r.mask       <= marked;
        res_r.frame_done <= frame_end;
        res_r.found      <= 1'b0;
        res_r.centroid_x <= cdmc_pkg::CENT_W'(cx_r);
        res_r.centroid_y <= cdmc_pkg::CENT_W'(cy_r);
        res_r.hit_count  <= cdmc_pkg::COUNT_W'(cnt_new);
      end
    end else if (cmd.step) begin
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
      dq_x_r  <= dq_x_nxt;
      dq_y_r  <= dq_y_nxt;
      if (cmd.finish) begin
        res_r.mask       <= pend_mask_r;
        res_r.frame_done <= 1'b1;
        res_r.found      <= 1'b1;
        res_r.centroid_x <= cdmc_pkg::CENT_W'(dq_x_nxt);
        res_r.centroid_y <= cdmc_pkg::CENT_W'(dq_y_nxt);
        res_r.hit_count  <= cdmc_pkg::COUNT_W'(pend_cnt_r);
      end
    end
  end

endmodule

/* rtl/core/cdmc_ctrl.sv */
// ---------------------------------------------------------------------------
// cdmc_ctrl
// Controller: input/output handshake, output register valid and the
// sequencing of the centroid division at frame end.
// ---------------------------------------------------------------------------
`include "color_dominance_mask_centroid_defines.svh"

module cdmc_ctrl #(
  parameter int DIV_STEPS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  cdmc_pkg::ctrl_sts_t  sts,
  output cdmc_pkg::ctrl_cmd_t  cmd
);

  localparam int CNTW = $clog2(DIV_STEPS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic             state_r;
  logic             state_nxt;
  logic [CNTW-1:0]  cnt_r;
  logic [CNTW-1:0]  cnt_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             last_step;

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign last_step = (state_r == ST_DIV) && (cnt_r == CNTW'(DIV_STEPS - 1));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          if (sts.need_div) begin
            state_nxt = ST_DIV;
            cnt_nxt   = '0;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (last_step) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CDMC_ASSERT_SAME(a_no_result_while_dividing, state_r == ST_DIV, !out_valid_r,
    "result register holds an item while a division is running")
  `CDMC_ASSERT_NEXT(a_div_after_hit_frame, in_valid && in_ready && sts.need_div,
    state_r == ST_DIV && !out_valid_r, "frame end with hits did not start a division")
  `CDMC_ASSERT_NEXT(a_result_after_div, last_step, out_valid_r && state_r == ST_IDLE,
    "division finished without presenting a result")
  `CDMC_ASSERT_NEXT(a_plain_item_result, in_valid && in_ready && !sts.need_div,
    out_valid_r && state_r == ST_IDLE, "accepted item did not produce a result")

endmodule

/* rtl/core/color_dominance_mask_centroid.sv */
// An ordinary pixel item's result is registered and valid in the cycle after it is accepted.
// A frame's last pixel with marked pixels starts the one-bit-per-cycle centroid divider;
// no further pixel item is accepted until the centroid result is registered.
// Sustained throughput is one pixel item per cycle while idle and results are taken.
// Synchronous active-low reset clears counters, sums, centroid and handshake state
// and loads the register reset values.
// ---------------------------------------------------------------------------
// color_dominance_mask_centroid
// Blue-dominance mask with per-frame blob centroid and hit count.
// ---------------------------------------------------------------------------
module color_dominance_mask_centroid #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  cdmc_pix_if.sink                      in_ch,
  cdmc_res_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cdmc_pkg::ADDR_W-1:0]   paddr,
  input  logic [cdmc_pkg::DATA_W-1:0]   pwdata,
  output logic [cdmc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int QW = (CW > RW) ? CW : RW;

  cdmc_pkg::cfg_t       cfg;
  cdmc_pkg::ctrl_cmd_t  cmd;
  cdmc_pkg::ctrl_sts_t  sts;
  cdmc_pkg::res_t       res;

  cdmc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cdmc_ctrl #(
    .DIV_STEPS (QW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cdmc_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .QW         (QW)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .red   (in_ch.red),
    .green (in_ch.green),
    .blue  (in_ch.blue),
    .cmd   (cmd),
    .sts   (sts),
    .res   (res)
  );

  assign out_ch.mask       = res.mask;
  assign out_ch.frame_done = res.frame_done;
  assign out_ch.found      = res.found;
  assign out_ch.centroid_x = res.centroid_x;
  assign out_ch.centroid_y = res.centroid_y;
  assign out_ch.hit_count  = res.hit_count;

endmodule

/* tb/sv/blob_centroid_checker.sv */
// ---------------------------------------------------------------------------
// Blob centroid checker
// Watches the pixel, result and register ports of the blue-dominance block,
// predicts every result item from its own copy of the frame state and
// compares the results field by field, in order.
// ---------------------------------------------------------------------------
module blob_centroid_checker
  import cdmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  cdmc_pix_if               pix_ch,
  cdmc_res_if               res_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                errors,
  output int                outstanding,
  output int                frames_done,
  output int                blobs_found
);

  localparam int unsigned MAX_SIDE = 1024;

  logic [THR_W-1:0]  margin_q;
  logic [SIZE_W-1:0] width_q;
  logic [SIZE_W-1:0] height_q;
  int unsigned       col_q;
  int unsigned       row_q;
  int unsigned       sum_col;
  int unsigned       sum_row;
  int unsigned       hits_q;
  int unsigned       cx_q;
  int unsigned       cy_q;
  res_t              pending_results[$];

  function automatic int unsigned clamp_side(logic [SIZE_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
  endfunction

  function automatic res_t predict_pixel(logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                                         logic [COLOR_W-1:0] b);
    res_t        res;
    int unsigned w;
    int unsigned h;
    logic        marked;
    logic        line_end;
    logic        frame_end;
    w = clamp_side(width_q);
    h = clamp_side(height_q);
    marked = (int'(b) > int'(r) + int'(margin_q)) && (int'(b) > int'(g) + int'(margin_q));
    line_end = (col_q + 1 >= w);
    frame_end = line_end && (row_q + 1 >= h);
    res = '0;
    if (marked) begin
      sum_col += col_q;
      sum_row += row_q;
      hits_q++;
    end
    res.hit_count = hits_q;
    if (frame_end) begin
      if (hits_q != 0) begin
        cx_q = sum_col / hits_q;
        cy_q = sum_row / hits_q;
        res.found = 1'b1;
      end
      sum_col = 0;
      sum_row = 0;
      hits_q = 0;
    end
    if (line_end) begin
      col_q = 0;
      row_q = frame_end ? 0 : row_q + 1;
    end else begin
      col_q++;
    end
    res.mask = marked;
    res.frame_done = frame_end;
    res.centroid_x = cx_q;
    res.centroid_y = cy_q;
    return res;
  endfunction

  function automatic void check_field(string field, logic [COUNT_W-1:0] want,
                                      logic [COUNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      margin_q = RST_MARGIN;
      width_q = RST_WIDTH;
      height_q = RST_HEIGHT;
      col_q = 0;
      row_q = 0;
      sum_col = 0;
      sum_row = 0;
      hits_q = 0;
      cx_q = 0;
      cy_q = 0;
      pending_results.delete();
      errors = 0;
      frames_done = 0;
      blobs_found = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_MARGIN: margin_q = pwdata[THR_W-1:0];
          REG_WIDTH:  width_q = pwdata[SIZE_W-1:0];
          REG_HEIGHT: height_q = pwdata[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (pix_ch.valid && pix_ch.ready) begin
        pending_results.push_back(predict_pixel(pix_ch.red, pix_ch.green, pix_ch.blue));
      end
      if (res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result item arrived while none was expected", $time);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("mask", want.mask, res_ch.mask);
          check_field("frame_done", want.frame_done, res_ch.frame_done);
          check_field("found", want.found, res_ch.found);
          check_field("centroid_x", want.centroid_x, res_ch.centroid_x);
          check_field("centroid_y", want.centroid_y, res_ch.centroid_y);
          check_field("hit_count", want.hit_count, res_ch.hit_count);
          if (want.frame_done) begin
            frames_done++;
          end
          if (want.found) begin
            blobs_found++;
          end
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

/* tb/sv/color_dominance_mask_centroid_tb.sv */
// ---------------------------------------------------------------------------
// Blue-dominance centroid testbench
// Drives pixel items and register writes into the block under random flow
// control, covers threshold overflow, empty frames, clamped and changed frame
// sizes, and lets the checker compare every result item.
// ---------------------------------------------------------------------------
module color_dominance_mask_centroid_tb;
  import cdmc_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int LIMIT_CYCLES = 500000;
  localparam int TAIL_CYCLES = 16;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pixel_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                src_gap_pct;
  int                sink_stall_pct;
  logic [THR_W-1:0]  cur_margin;
  int                pixels_sent;
  int                fail_count;
  int                pending;
  int                frame_count;
  int                blob_count;

  cdmc_pix_if pix_ch ();
  cdmc_res_if res_ch ();

  color_dominance_mask_centroid i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (pix_ch),
    .out_ch  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  blob_centroid_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_ch      (pix_ch),
    .res_ch      (res_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .errors      (fail_count),
    .outstanding (pending),
    .frames_done (frame_count),
    .blobs_found (blob_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(2 * LIMIT_CYCLES);
    $display("simulation failed");
    $finish;
  end

  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic logic [DATA_W-1:0] with_junk(logic [DATA_W-1:0] v, int bits);
    logic [DATA_W-1:0] keep;
    keep = (32'd1 << bits) - 1;
    return ($urandom_range(1) ? ($urandom & ~keep) : '0) | v;
  endfunction

  function automatic pixel_t make_pixel(int mark_pct);
    pixel_t p;
    int     lim;
    p.red = $urandom;
    p.green = $urandom;
    p.blue = $urandom;
    if ($urandom_range(99) < mark_pct && cur_margin != 8'hFF) begin
      p.blue = $urandom_range(255, int'(cur_margin) + 1);
      lim = int'(p.blue) - int'(cur_margin) - 1;
      p.red = $urandom_range(lim, 0);
      p.green = $urandom_range(lim, 0);
      case ($urandom_range(7))
        0: p.red = lim + 1;
        1: p.green = lim + 1;
        default: ;
      endcase
    end
    return p;
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_frame(logic [THR_W-1:0] margin, logic [SIZE_W-1:0] width,
                           logic [SIZE_W-1:0] height, logic spare);
    write_reg(REG_MARGIN, with_junk(margin, THR_W));
    write_reg(REG_WIDTH, with_junk(width, SIZE_W));
    write_reg(REG_HEIGHT, with_junk(height, SIZE_W));
    if (spare) begin
      write_reg(REG_SPARE, $urandom);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_margin = margin;
  endtask

  task automatic send_rgb(logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                          logic [COLOR_W-1:0] b);
    while ($urandom_range(99) < src_gap_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.red <= r;
    pix_ch.green <= g;
    pix_ch.blue <= b;
    do @(posedge clk); while (!pix_ch.ready);
    pixels_sent++;
  endtask

  task automatic wait_idle();
    pix_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int               n;
    int               pause_at;
    int               mark_pct;
    logic             big;
    logic [THR_W-1:0] m;
    pixel_t           p;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.red <= '0;
    pix_ch.green <= '0;
    pix_ch.blue <= '0;
    rst_n <= 1'b0;
    src_gap_pct = 0;
    sink_stall_pct = 0;
    cur_margin = RST_MARGIN;
    pixels_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // One 4x2 frame with four marked pixels, then three pixels into the next.
    set_frame(8'd0, 11'd4, 11'd2, 1'b0);
    send_rgb(8'd0, 8'd0, 8'd0);
    send_rgb(8'd255, 8'd255, 8'd255);
    send_rgb(8'd0, 8'd0, 8'd255);
    send_rgb(8'd255, 8'd0, 8'd255);
    send_rgb(8'd254, 8'd254, 8'd255);
    send_rgb(8'd0, 8'd255, 8'd255);
    send_rgb(8'd0, 8'd0, 8'd1);
    send_rgb(8'd128, 8'd127, 8'd200);
    send_rgb(8'd255, 8'd0, 8'd0);
    send_rgb(8'd0, 8'd255, 8'd0);
    send_rgb(8'd9, 8'd9, 8'd9);
    wait_idle();

    // The column now lies beyond the narrower line, so this pixel ends the frame.
    set_frame(8'd0, 11'd2, 11'd0, 1'b0);
    send_rgb(8'd10, 8'd20, 8'd30);
    wait_idle();

    // Single-pixel frames probe a wide margin, including sums above 255.
    set_frame(8'd200, 11'd0, 11'd0, 1'b0);
    send_rgb(8'd200, 8'd200, 8'd255);
    send_rgb(8'd55, 8'd0, 8'd255);
    send_rgb(8'd0, 8'd55, 8'd255);
    send_rgb(8'd54, 8'd54, 8'd255);
    send_rgb(8'd0, 8'd0, 8'd0);
    wait_idle();

    set_frame(8'd255, 11'd3, 11'd0, 1'b1);
    send_rgb(8'd0, 8'd0, 8'd255);
    send_rgb(8'd255, 8'd255, 8'd255);
    wait_idle();

    for (int mode = 0; mode < 3; mode++) begin
      src_gap_pct = (mode == 0) ? 13 : (mode == 1) ? 57 : 0;
      sink_stall_pct = (mode == 0) ? 57 : (mode == 1) ? 13 : 0;
      for (int ph = 0; ph < 5; ph++) begin
        big = (mode == 1) && (ph == 0);
        if (big) begin
          set_frame(8'd0, 11'd2047, 11'd1, 1'b0);
          n = 1030;
          mark_pct = 2;
        end else begin
          case ($urandom_range(3))
            0: m = 8'd0;
            1: m = 8'd255;
            2: m = $urandom_range(40);
            default: m = $urandom_range(255);
          endcase
          set_frame(m, $urandom_range(12), $urandom_range(6), $urandom_range(3) == 0);
          n = 30;
          mark_pct = $urandom_range(90);
        end
        pause_at = $urandom_range(n - 1);
        for (int k = 0; k < n; k++) begin
          p = make_pixel((big && k >= 1000) ? 40 : mark_pct);
          send_rgb(p.red, p.green, p.blue);
          if (k == pause_at) begin
            wait_idle();
          end
        end
        wait_idle();
      end
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d pixel items over directed cases and 15 register settings,",
             pixels_sent);
    $display("one a clamped 1024-pixel line; %0d frames ended, %0d with a blob found.",
             frame_count, blob_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/cdmc_pkg.sv
rtl/core/cdmc_ifs.sv
rtl/core/cdmc_regs.sv
rtl/core/cdmc_dp.sv
rtl/core/cdmc_ctrl.sv
rtl/core/color_dominance_mask_centroid.sv
tb/sv/blob_centroid_checker.sv
tb/sv/color_dominance_mask_centroid_tb.sv
